### src/ccc_pkg.sv
// Shared widths, defaults and types for the coin change combination counter.
package ccc_pkg;

    localparam int COIN_W       = 16;
    localparam int TARGET_W     = 12;
    localparam int COUNT_W      = 32;
    localparam int MAX_AMOUNT_D = 4095;

    typedef struct packed {
        logic [COUNT_W-1:0] combinations;
        logic               overflow;
    } ccc_result_t;

endpackage

### src/ccc_ways_ram.sv
// Way-count table: one write port, two registered read ports.
module ccc_ways_ram
    import ccc_pkg::*;
#(
    parameter int DEPTH = MAX_AMOUNT_D + 1,
    parameter int AW    = $clog2(MAX_AMOUNT_D + 1)
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [COUNT_W-1:0] wr_data,
    input  logic [AW-1:0]      rd_addr_a,
    input  logic [AW-1:0]      rd_addr_b,
    output logic [COUNT_W-1:0] rd_data_a,
    output logic [COUNT_W-1:0] rd_data_b
);

    logic [COUNT_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

### src/ccc_sweep_core.sv
// Sweep sequencer: clears the table, runs one read-add-write per entry, reads the answer.
module ccc_sweep_core
    import ccc_pkg::*;
#(
    parameter int MAX_AMOUNT = MAX_AMOUNT_D
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [TARGET_W-1:0] target_amount,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [COIN_W-1:0]   coin_value,
    input  logic                last_coin,
    output logic                res_valid,
    input  logic                res_ready,
    output ccc_result_t         res
);

    localparam int AW = (MAX_AMOUNT > 1) ? $clog2(MAX_AMOUNT + 1) : 1;
    localparam logic [AW-1:0]     MAX_IDX = AW'(MAX_AMOUNT);
    localparam logic [COIN_W-1:0] MAX_C   = COIN_W'(MAX_AMOUNT);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_SWEEP  = 6'b000100,
        ST_DRAIN  = 6'b001000,
        ST_READ   = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [AW-1:0]       coin_reg, coin_next;
    logic [AW-1:0]       tgt_reg, tgt_next;
    logic                last_reg, last_next;
    logic                p_vld_reg, p_vld_next;
    logic [AW-1:0]       p_addr_reg, p_addr_next;
    logic                fwd_reg, fwd_next;
    logic [COUNT_W-1:0]  fwd_data_reg, fwd_data_next;
    logic                ovf_reg, ovf_next;

    logic [COIN_W-1:0]   tgt_wide;
    logic [COIN_W-1:0]   eff_tgt;
    logic                do_sweep;
    logic [AW-1:0]       rd_hi_addr;
    logic [AW-1:0]       rd_lo_addr;
    logic [COUNT_W-1:0]  rd_hi_data;
    logic [COUNT_W-1:0]  rd_lo_data;
    logic [COUNT_W-1:0]  addend;
    logic [COUNT_W:0]    sum;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [COUNT_W-1:0]  wr_data;

    assign tgt_wide = COIN_W'(target_amount);
    assign eff_tgt  = (tgt_wide > MAX_C) ? MAX_C : tgt_wide;
    assign do_sweep = (coin_value != '0) && (coin_value <= eff_tgt);

    assign rd_hi_addr = (state_reg == ST_SWEEP) ? idx_reg : tgt_reg;
    assign rd_lo_addr = idx_reg - coin_reg;

    // The entry one coin lower may have been written in the very cycle it was read.
    assign addend = fwd_reg ? fwd_data_reg : rd_lo_data;
    assign sum    = {1'b0, rd_hi_data} + {1'b0, addend};

    assign wr_en   = (state_reg == ST_CLEAR) || p_vld_reg;
    assign wr_addr = (state_reg == ST_CLEAR) ? idx_reg : p_addr_reg;
    assign wr_data = (state_reg == ST_CLEAR) ? ((idx_reg == '0) ? COUNT_W'(1) : '0)
                                             : sum[COUNT_W-1:0];

    assign in_ready         = (state_reg == ST_IDLE);
    assign res_valid        = (state_reg == ST_RESULT);
    assign res.combinations = rd_hi_data;
    assign res.overflow     = ovf_reg;

    ccc_ways_ram #(
        .DEPTH (MAX_AMOUNT + 1),
        .AW    (AW)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_hi_addr),
        .rd_addr_b (rd_lo_addr),
        .rd_data_a (rd_hi_data),
        .rd_data_b (rd_lo_data)
    );

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        coin_next     = coin_reg;
        tgt_next      = tgt_reg;
        last_next     = last_reg;
        p_vld_next    = 1'b0;
        p_addr_next   = p_addr_reg;
        fwd_next      = 1'b0;
        fwd_data_next = sum[COUNT_W-1:0];
        ovf_next      = ovf_reg;

        if (p_vld_reg && sum[COUNT_W])
        begin
            ovf_next = 1'b1;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                idx_next = idx_reg + AW'(1);
                if (idx_reg == MAX_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    tgt_next  = eff_tgt[AW-1:0];
                    coin_next = coin_value[AW-1:0];
                    idx_next  = coin_value[AW-1:0];
                    last_next = last_coin;
                    if (do_sweep)
                    begin
                        state_next = ST_SWEEP;
                    end
                    else if (last_coin)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_SWEEP:
            begin
                p_vld_next  = 1'b1;
                p_addr_next = idx_reg;
                fwd_next    = p_vld_reg && (rd_lo_addr == p_addr_reg);
                idx_next    = idx_reg + AW'(1);
                if (idx_reg == tgt_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = last_reg ? ST_READ : ST_IDLE;
            end
            ST_READ:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (res_ready)
                begin
                    ovf_next   = 1'b0;
                    idx_next   = '0;
                    state_next = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            idx_reg   <= '0;
            p_vld_reg <= 1'b0;
            fwd_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            p_vld_reg <= p_vld_next;
            fwd_reg   <= fwd_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        coin_reg     <= coin_next;
        tgt_reg      <= tgt_next;
        last_reg     <= last_next;
        p_addr_reg   <= p_addr_next;
        fwd_data_reg <= fwd_data_next;
    end

endmodule

### src/coin_change_combination_counter_top.sv
// Top level of the coin change combination counter: ports, target register, result register.
//
// Feed one coin denomination per word on s_axis (tdata = coin_value, tlast = last_coin).
// Each coin sweeps the way-count table from its value up to the target, one
// read-add-write per cycle through a single adder and a two-read, one-write table.
// A zero coin, or one above the target, runs no sweep. The word marked tlast then has the
// answer read, and a clearing pass over every entry from 0 to MAX_AMOUNT returns the
// table to one way for amount zero; s_axis_tready stays low throughout all of this.
// The answer leaves on m_axis as one word: tdata = combinations, tuser = overflow
// (sticky over the whole coin list). A single output register holds it; when the
// receiver stalls, the clearing pass still runs, and only a further answer waits.
// Write target_amount on the cfg channel (always ready) only while the block is idle.
// After reset the clearing pass runs first over every entry, then tready rises;
// target_amount resets to 0. A target above MAX_AMOUNT saturates to MAX_AMOUNT.
module coin_change_combination_counter_top
    import ccc_pkg::*;
#(
    parameter int MAX_AMOUNT = MAX_AMOUNT_D
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [15:0]         s_axis_tdata,    // [15:0] coin_value
    input  logic                s_axis_tlast,    // last_coin
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [31:0]         m_axis_tdata,    // [31:0] combinations
    output logic                m_axis_tuser,    // [0] overflow
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [TARGET_W-1:0] cfg_data         // target_amount
);

    logic [TARGET_W-1:0] target_reg;
    logic                out_vld_reg;
    ccc_result_t         out_reg;
    logic                res_valid;
    logic                res_ready;
    ccc_result_t         res;

    assign cfg_ready = 1'b1;

    // Hold the target between writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            target_reg <= cfg_data;
        end
    end

    ccc_sweep_core #(
        .MAX_AMOUNT (MAX_AMOUNT)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .target_amount (target_reg),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .coin_value    (s_axis_tdata),
        .last_coin     (s_axis_tlast),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res)
    );

    // Load the result register whenever it is empty or being emptied this cycle.
    assign res_ready = !out_vld_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_vld_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_reg.combinations;
    assign m_axis_tuser  = out_reg.overflow;

endmodule
